/* rtl/core/nodelist_line_indexer_core_assert.svh */
// Assertion macros shared by the indexer core.
// Clock clk and active-low reset arst_n are taken from the module scope.
`ifndef NODELIST_LINE_INDEXER_CORE_ASSERT_SVH
`define NODELIST_LINE_INDEXER_CORE_ASSERT_SVH

// Same-cycle implication.
`define NLI_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("indexer assertion failed");

// Next-cycle implication.
`define NLI_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("indexer assertion failed");

`endif

/* rtl/core/nli_pkg.sv */
package nli_pkg;

	typedef enum logic [2:0] {
		KW_ZONE   = 3'd0,
		KW_REGION = 3'd1,
		KW_HOST   = 3'd2,
		KW_HUB    = 3'd3,
		KW_COMMA  = 3'd4,
		KW_POINT  = 3'd5,
		KW_NONE   = 3'd7
	} kw_t;

	typedef enum logic [1:0] {
		PH_BLANKS = 2'd0,
		PH_DIGITS = 2'd1,
		PH_DONE   = 2'd2
	} phase_t;

	localparam int NUM_KW  = 6;
	localparam int KW_COLS = 7;

	localparam logic [2:0] COL_LIMIT = 3'd7;

	// Keyword text, lower case.
	localparam logic [7:0] KW_TEXT [NUM_KW][KW_COLS] = '{
		'{"z", "o", "n", "e", ",", 8'h00, 8'h00},
		'{"r", "e", "g", "i", "o", "n", ","},
		'{"h", "o", "s", "t", ",", 8'h00, 8'h00},
		'{"h", "u", "b", ",", 8'h00, 8'h00, 8'h00},
		'{",", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"p", "o", "i", "n", "t", ",", 8'h00}
	};
	localparam logic [2:0] KW_LEN [NUM_KW] = '{3'd5, 3'd7, 3'd5, 3'd4, 3'd1, 3'd6};

	localparam logic [7:0] CH_NL    = 8'd10;
	localparam logic [7:0] CH_TAB   = 8'd9;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_SPACE = " ";
	localparam logic [7:0] CH_PLUS  = "+";
	localparam logic [7:0] CH_MINUS = "-";
	localparam logic [7:0] CH_ZERO  = "0";
	localparam logic [7:0] CH_NINE  = "9";
	localparam logic [7:0] CH_UP_A  = "A";
	localparam logic [7:0] CH_UP_Z  = "Z";
	localparam logic [7:0] CASE_GAP = 8'd32;

	localparam logic [31:0] TERM_OFFSET = 32'hFFFF_FFFF;

	// One line-end or end-of-file event from the parser.
	typedef struct packed {
		kw_t         kw;
		logic [15:0] value;
		logic        neg;
		logic [31:0] line_start;
		logic        eof;
		logic [15:0] zone_base;
	} ev_t;

	typedef struct packed {
		logic [15:0] zone;
		logic [15:0] region;
		logic [15:0] net;
		logic [15:0] hub;
		logic [15:0] node;
		logic [15:0] point;
	} lvl_t;

	typedef struct packed {
		logic [15:0] zone;
		logic [15:0] net;
		logic [15:0] node;
		logic [15:0] point;
		logic [15:0] region;
		logic [15:0] hub;
		logic [31:0] offset;
		logic        last;
	} rec_t;

	typedef struct packed {
		logic pop;
		logic term_pend;
	} back_stat_t;

endpackage

/* rtl/core/nodelist_line_indexer_core.sv */
// Nodelist line indexer: one text byte per cycle while the event queue is not full.
// A line record passes through the event queue and then the output register before it is valid on the output.
// A keyword line ended by the end-of-file byte gives two output records (record, terminator);
// the event queue of QUEUE_DEPTH entries absorbs that, the input stalls only when it is full.
// Reset (arst_n low): parser, queue and output clear at once, default zone reads 0;
// no clearing pass, the first byte may follow straight after reset.
`include "nodelist_line_indexer_core_assert.svh"

module nodelist_line_indexer_core #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic [15:0]   cfg_wdata,
	input  logic          s_axis_tvalid,
	output logic          s_axis_tready,
	input  logic [7:0]    s_axis_tdata,   // text_byte
	input  logic          s_axis_tlast,   // end_of_file
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	// zone_num, net_num, node_num, point_num, region_num, hub_num, line_offset
	output logic [127:0]  m_axis_tdata,
	output logic          m_axis_tlast    // last_of_run
);

	logic [15:0]          default_zone_q;
	logic                 q_push, q_empty, q_full;
	nli_pkg::ev_t         q_wdata, q_head;
	nli_pkg::back_stat_t  b_stat;
	nli_pkg::rec_t        rec;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			default_zone_q <= '0;
		else if (cfg_we)
			default_zone_q <= cfg_wdata;
	end

	nli_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.default_zone (default_zone_q),
		.in_valid     (s_axis_tvalid),
		.in_ready     (s_axis_tready),
		.text_byte    (s_axis_tdata),
		.end_of_file  (s_axis_tlast),
		.q_full       (q_full),
		.ev_push      (q_push),
		.ev           (q_wdata)
	);

	nli_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (b_stat.pop),
		.rdata  (q_head),
		.empty  (q_empty),
		.full   (q_full)
	);

	nli_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (q_head),
		.q_empty   (q_empty),
		.stat      (b_stat),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_rec   (rec)
	);

	assign m_axis_tdata = {rec.offset, rec.hub, rec.region, rec.point,
		rec.node, rec.net, rec.zone};
	assign m_axis_tlast = rec.last;

	`NLI_ASSERT_IMPL(a_pop_not_empty, b_stat.pop, !q_empty)
	`NLI_ASSERT_IMPL(a_term_pend_on_eof, b_stat.term_pend, !q_empty && q_head.eof)
	`NLI_ASSERT_NEXT(a_eof_queued, s_axis_tvalid && s_axis_tready && s_axis_tlast, !q_empty)

endmodule

/* rtl/core/nli_fifo.sv */
module nli_fifo #(
	parameter int DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  nli_pkg::ev_t  wdata,
	input  logic          pop,
	output nli_pkg::ev_t  rdata,
	output logic          empty,
	output logic          full
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	nli_pkg::ev_t   mem [DEPTH];
	logic [AW-1:0]  wr_ptr_q;
	logic [AW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == CW'(DEPTH));
	assign rdata = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem[wr_ptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			if (pop)
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			if (push && !pop)
				count_q <= count_q + CW'(1);
			else if (pop && !push)
				count_q <= count_q - CW'(1);
		end
	end

endmodule

/* rtl/core/nli_front.sv */
module nli_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [15:0]   default_zone,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [7:0]    text_byte,
	input  logic          end_of_file,
	input  logic          q_full,
	output logic          ev_push,
	output nli_pkg::ev_t  ev
);

	logic [31:0]      pos_q;
	logic [31:0]      line_start_q;
	logic [5:0]       cand_q, cand_n;
	logic [2:0]       col_q, col_n;
	nli_pkg::kw_t     kw_q, kw_n, hit_kw;
	nli_pkg::phase_t  phase_q, phase_n;
	logic [15:0]      num_q, num_n, acc;
	logic             neg_q, neg_n;
	logic             in_file_q;
	logic [15:0]      zone_base_q;

	logic [7:0]  lb;
	logic        digit, blank, line_end, accept, hit;
	logic [3:0]  dval;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		lb       = (text_byte >= nli_pkg::CH_UP_A && text_byte <= nli_pkg::CH_UP_Z)
			? text_byte + nli_pkg::CASE_GAP : text_byte;
		digit    = (text_byte >= nli_pkg::CH_ZERO && text_byte <= nli_pkg::CH_NINE);
		blank    = (text_byte == nli_pkg::CH_SPACE)
			|| (text_byte >= nli_pkg::CH_TAB && text_byte <= nli_pkg::CH_CR);
		dval     = 4'(text_byte - nli_pkg::CH_ZERO);
		acc      = {num_q[12:0], 3'b000} + {num_q[14:0], 1'b0} + {12'd0, dval};
		line_end = (text_byte == nli_pkg::CH_NL) || end_of_file;

		cand_n  = cand_q;
		col_n   = col_q;
		kw_n    = kw_q;
		phase_n = phase_q;
		num_n   = num_q;
		neg_n   = neg_q;
		hit     = 1'b0;
		hit_kw  = nli_pkg::KW_NONE;

		if (kw_q != nli_pkg::KW_NONE) begin
			unique case (phase_q)
				nli_pkg::PH_BLANKS: begin
					if (blank) begin
						phase_n = phase_q;
					end else if (text_byte == nli_pkg::CH_PLUS) begin
						phase_n = nli_pkg::PH_DIGITS;
					end else if (text_byte == nli_pkg::CH_MINUS) begin
						neg_n   = 1'b1;
						phase_n = nli_pkg::PH_DIGITS;
					end else if (digit) begin
						phase_n = nli_pkg::PH_DIGITS;
						num_n   = acc;
					end else begin
						phase_n = nli_pkg::PH_DONE;
					end
				end
				nli_pkg::PH_DIGITS: begin
					if (digit)
						num_n = acc;
					else
						phase_n = nli_pkg::PH_DONE;
				end
				default: ;
			endcase
		end else if (col_q != nli_pkg::COL_LIMIT && cand_q != '0) begin
			// at most one keyword can complete on a given column
			for (int k = 0; k < nli_pkg::NUM_KW; k++) begin
				if (cand_q[k]) begin
					if (col_q < nli_pkg::KW_LEN[k] && nli_pkg::KW_TEXT[k][col_q] == lb) begin
						if (col_q == nli_pkg::KW_LEN[k] - 3'd1) begin
							hit    = 1'b1;
							hit_kw = nli_pkg::kw_t'(3'(k));
						end
					end else begin
						cand_n[k] = 1'b0;
					end
				end
			end
			col_n = col_q + 3'd1;
			if (hit) begin
				kw_n    = hit_kw;
				cand_n  = '0;
				phase_n = nli_pkg::PH_BLANKS;
				num_n   = '0;
				neg_n   = 1'b0;
			end
		end

		ev.kw         = kw_n;
		ev.value      = num_n;
		ev.neg        = neg_n;
		ev.line_start = line_start_q;
		ev.eof        = end_of_file;
		ev.zone_base  = in_file_q ? zone_base_q : default_zone;
		ev_push       = accept && ((line_end && kw_n != nli_pkg::KW_NONE) || end_of_file);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= '0;
			line_start_q <= '0;
			cand_q       <= '1;
			col_q        <= '0;
			kw_q         <= nli_pkg::KW_NONE;
			phase_q      <= nli_pkg::PH_BLANKS;
			num_q        <= '0;
			neg_q        <= 1'b0;
			in_file_q    <= 1'b0;
			zone_base_q  <= '0;
		end else if (accept) begin
			pos_q       <= end_of_file ? '0 : pos_q + 32'd1;
			in_file_q   <= !end_of_file;
			zone_base_q <= ev.zone_base;
			if (line_end) begin
				// drop the line parse state, next line starts after this byte
				line_start_q <= end_of_file ? '0 : pos_q + 32'd1;
				cand_q       <= '1;
				col_q        <= '0;
				kw_q         <= nli_pkg::KW_NONE;
				phase_q      <= nli_pkg::PH_BLANKS;
				num_q        <= '0;
				neg_q        <= 1'b0;
			end else begin
				cand_q  <= cand_n;
				col_q   <= col_n;
				kw_q    <= kw_n;
				phase_q <= phase_n;
				num_q   <= num_n;
				neg_q   <= neg_n;
			end
		end
	end

endmodule

/* rtl/core/nli_back.sv */
module nli_back (
	input  logic                clk,
	input  logic                arst_n,
	input  nli_pkg::ev_t        head,
	input  logic                q_empty,
	output nli_pkg::back_stat_t stat,
	output logic                out_valid,
	input  logic                out_ready,
	output nli_pkg::rec_t       out_rec
);

	nli_pkg::lvl_t  lvl_q, base, lvl_n;
	nli_pkg::rec_t  rec_q, line_rec, term_rec;
	logic           out_valid_q;
	logic           fresh_q;
	logic           term_pend_q;
	logic           load, go, do_line;
	logic [15:0]    val;

	always_comb begin
		load    = !out_valid_q || out_ready;
		go      = load && !q_empty;
		do_line = (head.kw != nli_pkg::KW_NONE) && !term_pend_q;
		val     = head.neg ? 16'd0 - head.value : head.value;

		if (fresh_q) begin
			base      = '0;
			base.zone = head.zone_base;
		end else begin
			base = lvl_q;
		end

		lvl_n = base;
		unique case (head.kw)
			nli_pkg::KW_ZONE: begin
				lvl_n.zone   = val;
				lvl_n.region = '0;
				lvl_n.net    = val;
				lvl_n.hub    = '0;
				lvl_n.node   = '0;
				lvl_n.point  = '0;
			end
			nli_pkg::KW_REGION: begin
				lvl_n.region = val;
				lvl_n.net    = val;
				lvl_n.hub    = '0;
				lvl_n.node   = '0;
				lvl_n.point  = '0;
			end
			nli_pkg::KW_HOST: begin
				lvl_n.net   = val;
				lvl_n.hub   = '0;
				lvl_n.node  = '0;
				lvl_n.point = '0;
			end
			nli_pkg::KW_HUB: begin
				lvl_n.hub   = val;
				lvl_n.node  = val;
				lvl_n.point = '0;
			end
			nli_pkg::KW_COMMA: begin
				lvl_n.node  = val;
				lvl_n.point = '0;
			end
			default: lvl_n.point = val;
		endcase

		line_rec.zone   = lvl_n.zone;
		line_rec.net    = lvl_n.net;
		line_rec.node   = lvl_n.node;
		line_rec.point  = lvl_n.point;
		line_rec.region = lvl_n.region;
		line_rec.hub    = lvl_n.hub;
		line_rec.offset = head.line_start;
		line_rec.last   = !head.eof;

		term_rec        = '0;
		term_rec.offset = nli_pkg::TERM_OFFSET;
		term_rec.last   = 1'b1;

		// an end-of-file event with a keyword line gives two records: hold it once
		stat.pop       = go && !(do_line && head.eof);
		stat.term_pend = term_pend_q;
	end

	assign out_valid = out_valid_q;
	assign out_rec   = rec_q;

	always_ff @(posedge clk) begin
		if (go)
			rec_q <= do_line ? line_rec : term_rec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			fresh_q     <= 1'b1;
			term_pend_q <= 1'b0;
			lvl_q       <= '0;
		end else if (go) begin
			out_valid_q <= 1'b1;
			if (do_line) begin
				lvl_q       <= lvl_n;
				fresh_q     <= 1'b0;
				term_pend_q <= head.eof;
			end else begin
				fresh_q     <= 1'b1;
				term_pend_q <= 1'b0;
			end
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule
